// ===== hw/rtl/hns_pkg.sv =====
// Shared constants and types of the heightmap normal stream.
package hns_pkg;

  localparam int unsigned MAX_SIDE_DEF = 513;
  localparam int unsigned MAP_SIDE_W   = 10;
  localparam int unsigned HEIGHT_W     = 8;
  localparam int unsigned SUM_W        = 17;
  localparam int unsigned MAG_W        = 15;
  localparam logic [MAG_W-1:0] ONE_Q   = 15'd32767;
  // 4 * 32767 * 32767
  localparam logic [31:0] FOUR_K2      = 32'd4294705156;
  localparam logic [MAP_SIDE_W-1:0] MAP_SIDE_RESET = 10'd513;

  // Result kinds released by one input sample
  localparam logic [1:0] JOB_A = 2'd0;  // point of the previous row
  localparam logic [1:0] JOB_B = 2'd1;  // left neighbor on the last row
  localparam logic [1:0] JOB_C = 2'd2;  // last point of the last row

  typedef struct packed {
    logic                start;
    logic [HEIGHT_W-1:0] mag;
    logic [SUM_W-1:0]    sum;
  } mag_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] value;
  } mag_rsp_t;

endpackage

// ===== hw/rtl/heightmap_normal_stream.sv =====
// Flow: a sample is taken while the sequencer is idle; for each result that it releases, four operands
// are read from the row buffers, the slopes are formed, three magnitude passes run (15 square-and-compare
// steps each) and the result goes to the output register, which holds while the output is stalled.
// Throughput: one sample a cycle on the first row; a sample that releases results holds off the next
// sample until its last result has been delivered, plus any output stall.
// Reset: counters, rotation and handshakes clear; row buffers stay undefined until written.
module heightmap_normal_stream #(
  parameter int unsigned MAX_SIDE = hns_pkg::MAX_SIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [hns_pkg::MAP_SIDE_W-1:0] cfg_data_i,  // map_side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // height[7:0]
  input  logic        s_axis_tuser_i,   // start_of_map
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // normal_x[15:0], normal_y[31:16], normal_z[46:32], point_column[56:47],
  // point_row[66:57], zero fill[71:67]
  output logic [71:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o    // last_of_run
);
  import hns_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned SW    = (CW > MAP_SIDE_W) ? CW : MAP_SIDE_W;
  localparam int unsigned DEPTH = 3 * MAX_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_CALC   = 3'd3;
  localparam logic [2:0] S_MSTART = 3'd4;
  localparam logic [2:0] S_MWAIT  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  typedef struct packed {
    logic          use_in;
    logic [1:0]    slot;
    logic [CW-1:0] col;
  } opd_t;

  logic [MAP_SIDE_W-1:0] map_side_q;
  logic [CW-1:0]         col_cnt_q, row_cnt_q;
  logic [1:0]            rot_q;

  logic [2:0]          state_q;
  logic [HEIGHT_W-1:0] hin_q;
  logic [CW-1:0]       c_q, r_q, sm1_q;
  logic [1:0]          cur_q, prv_q, pp_q;
  logic                jb_q, jc_q;
  logic [1:0]          job_q;
  logic [1:0]          k_q;
  logic [1:0]          comp_q;
  logic [HEIGHT_W-1:0] opv_q [4];
  logic [HEIGHT_W-1:0] ax_q, ay_q;
  logic                negx_q, negy_q;
  logic [SUM_W-1:0]    s_q;
  logic [MAG_W-1:0]    mx_q, my_q, mz_q;

  logic                m_valid_q;
  logic [71:0]         m_data_q;
  logic                m_last_q;

  logic [SW-1:0]  ms_ext;
  logic [CW-1:0]  side, sm1;
  logic [CW-1:0]  c_eff, r_eff;
  logic [1:0]     rot_eff, prv_eff, pp_eff;
  logic           accept;
  logic           ja, jb, jc;
  opd_t           opd [4];
  opd_t           sel;
  logic [AW-1:0]  waddr, raddr;
  logic [HEIGHT_W-1:0] rdata;
  logic           has_next;
  logic [1:0]     next_job;
  logic           out_free;
  logic [CW-1:0]  pcol, prow;
  logic [8:0]     dx, dy;
  logic [HEIGHT_W-1:0] ax, ay;
  mag_req_t       mag_req;
  mag_rsp_t       mag_rsp;
  logic [15:0]    nx, ny;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Clamp the side to the supported range
  always_comb begin
    ms_ext = SW'(map_side_q);
    if (ms_ext < SW'(3)) begin
      side = CW'(3);
    end else if (ms_ext > SW'(MAX_SIDE)) begin
      side = CW'(MAX_SIDE);
    end else begin
      side = CW'(ms_ext);
    end
    sm1 = side - CW'(1);
  end

  // Position of the incoming sample after start mark and saturation
  always_comb begin
    c_eff   = s_axis_tuser_i ? '0 : col_cnt_q;
    r_eff   = s_axis_tuser_i ? '0 : row_cnt_q;
    rot_eff = s_axis_tuser_i ? 2'd0 : rot_q;
    if (c_eff > sm1) c_eff = sm1;
    if (r_eff > sm1) r_eff = sm1;
    if (rot_eff > 2'd2) rot_eff = 2'd0;
    case (rot_eff)
      2'd0:    begin prv_eff = 2'd2; pp_eff = 2'd1; end
      2'd1:    begin prv_eff = 2'd0; pp_eff = 2'd2; end
      default: begin prv_eff = 2'd1; pp_eff = 2'd0; end
    endcase
    ja = (r_eff != '0);
    jb = (r_eff == sm1) && (c_eff != '0);
    jc = (r_eff == sm1) && (c_eff == sm1);
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_side_q <= MAP_SIDE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      map_side_q <= cfg_data_i;
    end
  end

  // Advance raster counters and buffer rotation on each transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      rot_q     <= 2'd0;
    end else if (accept) begin
      if (c_eff >= sm1) begin
        col_cnt_q <= '0;
        rot_q     <= (rot_eff == 2'd2) ? 2'd0 : rot_eff + 2'd1;
        row_cnt_q <= (r_eff >= sm1) ? '0 : r_eff + CW'(1);
      end else begin
        col_cnt_q <= c_eff + CW'(1);
        row_cnt_q <= r_eff;
        rot_q     <= rot_eff;
      end
    end
  end

  // Hold the item context
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hin_q <= s_axis_tdata_i;
      c_q   <= c_eff;
      r_q   <= r_eff;
      sm1_q <= sm1;
      cur_q <= rot_eff;
      prv_q <= prv_eff;
      pp_q  <= pp_eff;
      jb_q  <= jb;
      jc_q  <= jc;
    end
  end

  // Operands of the current result: Dx = op0 - op1, Dy = op2 - op3
  always_comb begin
    for (int i = 0; i < 4; i++) opd[i] = '0;
    case (job_q)
      JOB_A: begin
        if (c_q == '0) begin
          opd[0] = '{1'b0, prv_q, CW'(1)};
          opd[1] = '{1'b0, prv_q, CW'(0)};
        end else if (c_q >= sm1_q) begin
          opd[0] = '{1'b0, prv_q, c_q};
          opd[1] = '{1'b0, prv_q, c_q - CW'(1)};
        end else begin
          opd[0] = '{1'b0, prv_q, c_q + CW'(1)};
          opd[1] = '{1'b0, prv_q, c_q - CW'(1)};
        end
        opd[2] = '{1'b1, cur_q, c_q};
        opd[3] = '{1'b0, (r_q == CW'(1)) ? prv_q : pp_q, c_q};
      end
      JOB_B: begin
        opd[0] = '{1'b1, cur_q, c_q};
        opd[1] = '{1'b0, cur_q, (c_q == CW'(1)) ? CW'(0) : c_q - CW'(2)};
        opd[2] = '{1'b0, cur_q, c_q - CW'(1)};
        opd[3] = '{1'b0, prv_q, c_q - CW'(1)};
      end
      default: begin
        opd[0] = '{1'b1, cur_q, c_q};
        opd[1] = '{1'b0, cur_q, c_q - CW'(1)};
        opd[2] = '{1'b1, cur_q, c_q};
        opd[3] = '{1'b0, prv_q, c_q};
      end
    endcase
    sel = opd[k_q];
  end

  assign waddr = AW'(rot_eff) * AW'(MAX_SIDE) + AW'(c_eff);
  assign raddr = AW'(sel.slot) * AW'(MAX_SIDE) + AW'(sel.col);

  hns_rowbuf #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_rowbuf (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (state_q == S_RD),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Slopes and their absolute values
  assign dx = {1'b0, opv_q[0]} - {1'b0, opv_q[1]};
  assign dy = {1'b0, opv_q[2]} - {1'b0, opv_q[3]};
  assign ax = dx[8] ? HEIGHT_W'(9'd0 - dx) : dx[7:0];
  assign ay = dy[8] ? HEIGHT_W'(9'd0 - dy) : dy[7:0];

  // Magnitude requests: x, y, then the constant z term
  always_comb begin
    mag_req.start = (state_q == S_MSTART);
    mag_req.sum   = s_q;
    case (comp_q)
      2'd0:    mag_req.mag = ax_q;
      2'd1:    mag_req.mag = ay_q;
      default: mag_req.mag = HEIGHT_W'(2);
    endcase
  end

  hns_mag u_mag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mag_req),
    .rsp_o  (mag_rsp)
  );

  // Next result of this sample
  always_comb begin
    next_job = JOB_C;
    has_next = 1'b0;
    if ((job_q == JOB_A) && jb_q) begin
      next_job = JOB_B;
      has_next = 1'b1;
    end else if (((job_q == JOB_A) || (job_q == JOB_B)) && jc_q) begin
      next_job = JOB_C;
      has_next = 1'b1;
    end
  end

  // Grid point of the current result
  always_comb begin
    case (job_q)
      JOB_A:   begin pcol = c_q;          prow = r_q - CW'(1); end
      JOB_B:   begin pcol = c_q - CW'(1); prow = r_q;          end
      default: begin pcol = c_q;          prow = r_q;          end
    endcase
  end

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign nx = negx_q ? 16'd0 - {1'b0, mx_q} : {1'b0, mx_q};
  assign ny = negy_q ? 16'd0 - {1'b0, my_q} : {1'b0, my_q};

  // Sequencer: read operands, run the magnitude unit, deliver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= JOB_A;
      k_q     <= 2'd0;
      comp_q  <= 2'd0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && (ja || jb || jc)) begin
            state_q <= S_RD;
            k_q     <= 2'd0;
            job_q   <= ja ? JOB_A : (jb ? JOB_B : JOB_C);
          end
        end
        S_RD: state_q <= S_WAIT;
        S_WAIT: begin
          if (k_q == 2'd3) begin
            state_q <= S_CALC;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_RD;
          end
        end
        S_CALC: begin
          comp_q  <= 2'd0;
          state_q <= S_MSTART;
        end
        S_MSTART: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (mag_rsp.done) begin
            if (comp_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= S_MSTART;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (has_next) begin
              job_q   <= next_job;
              k_q     <= 2'd0;
              state_q <= S_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the sequencer
  always_ff @(posedge clk_i) begin
    if (state_q == S_WAIT) begin
      opv_q[k_q] <= sel.use_in ? hin_q : rdata;
    end
    if (state_q == S_CALC) begin
      ax_q   <= ax;
      ay_q   <= ay;
      negx_q <= !dx[8] && (dx != '0);
      negy_q <= !dy[8] && (dy != '0);
      s_q    <= SUM_W'(16'(ax) * 16'(ax)) + SUM_W'(16'(ay) * 16'(ay)) + SUM_W'(4);
    end
    if ((state_q == S_MWAIT) && mag_rsp.done) begin
      if (comp_q == 2'd0) mx_q <= mag_rsp.value;
      if (comp_q == 2'd1) my_q <= mag_rsp.value;
      if (comp_q == 2'd2) mz_q <= mag_rsp.value;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      m_data_q <= {5'd0, 10'(prow), 10'(pcol), mz_q, ny, nx};
      m_last_q <= !has_next;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

`ifndef SYNTH
  // The magnitude unit answers only while a request is outstanding
  a_mag_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_rsp.done |-> (state_q == S_MWAIT))
    else $error("magnitude result outside of a request");

  // The z component of a delivered normal is never zero
  a_nz_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[46:32] != 15'd0))
    else $error("normal_z is zero");

  // The x component never falls below minus one (-32767)
  a_nx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[15:0] != 16'h8000))
    else $error("normal_x out of range");
`endif

endmodule

// ===== hw/rtl/hns_rowbuf.sv =====
// Row buffer memory: one write port, one registered read port.
module hns_rowbuf #(
  parameter int unsigned DEPTH = 3 * hns_pkg::MAX_SIDE_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [hns_pkg::HEIGHT_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [hns_pkg::HEIGHT_W-1:0] rdata_o
);
  import hns_pkg::*;

  logic [HEIGHT_W-1:0] mem [DEPTH];
  logic [HEIGHT_W-1:0] rdata_q;

  // Write the sample
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one entry a cycle while the read enable is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hns_mag.sv =====
// Iterative unit: nearest integer to 32767*a/sqrt(s) by binary search.
module hns_mag (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hns_pkg::mag_req_t req_i,
  output hns_pkg::mag_rsp_t rsp_o
);
  import hns_pkg::*;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_TA   = 3'd1;
  localparam logic [2:0] M_TB   = 3'd2;
  localparam logic [2:0] M_SQ   = 3'd3;
  localparam logic [2:0] M_CMP  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [HEIGHT_W-1:0] a_q;
  logic [SUM_W-1:0]    s_q;
  logic [15:0]         asq_q;
  logic [47:0]         tgt_q;
  logic [MAG_W-1:0]    lo_q, hi_q, mid_q;
  logic [31:0]         tt_q;
  logic                done_q;
  logic [15:0]         mid_sum;
  logic [MAG_W-1:0]    mid;
  logic [15:0]         t_odd;
  logic [48:0]         prod;

  // Midpoint and odd test value 2*mid-1
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 16'd1;
  assign mid     = mid_sum[15:1];
  assign t_odd   = {mid, 1'b0} - 16'd1;
  assign prod    = 49'(tt_q) * 49'(s_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      M_IDLE: if (req_i.start) state_d = M_TA;
      M_TA:   state_d = M_TB;
      M_TB:   state_d = M_SQ;
      M_SQ:   state_d = (lo_q < hi_q) ? M_CMP : M_IDLE;
      M_CMP:  state_d = M_SQ;
      default: state_d = M_IDLE;
    endcase
  end

  // Sequencer state and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == M_SQ) && !(lo_q < hi_q);
    end
  end

  // Datapath: target, then one square and one compare per step
  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          a_q  <= req_i.mag;
          s_q  <= req_i.sum;
          lo_q <= '0;
          hi_q <= ONE_Q;
        end
      end
      M_TA: asq_q <= 16'(a_q) * 16'(a_q);
      M_TB: tgt_q <= 48'(asq_q) * 48'(FOUR_K2);
      M_SQ: begin
        mid_q <= mid;
        tt_q  <= 32'(t_odd) * 32'(t_odd);
      end
      M_CMP: begin
        if (prod <= {1'b0, tgt_q}) begin
          lo_q <= mid_q;
        end else begin
          hi_q <= mid_q - 15'd1;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = lo_q;

endmodule
